/* hdl/pwl_pkg.sv */
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared types and constants for the piecewise-linear curve evaluator.
// ----------------------------------------------------------------------------
package pwl_pkg;

   // Default sizes of the breakpoint table and of one Q8.16 value
   localparam int MAX_POINTS_DEF  = 16;
   localparam int VALUE_WIDTH_DEF = 24;

   // Fixed field widths
   localparam int COUNT_W = 5;   // point_count register
   localparam int SLOT_W  = 4;   // point_index field
   localparam int SEG_W   = 4;   // segment field

   // Item kind carried in req_tuser
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Commands from sequencer to datapath
   typedef struct packed {
      logic             load_sample;
      logic             table_write;
      logic             rd_en;
      logic             capture_prev;
      logic             div_start;
      logic             div_step;
      logic             out_load;
      logic             out_below;
      logic             out_beyond;
      logic [SEG_W-1:0] segment;
   } cmd_type;

   // Status from datapath to sequencer
   typedef struct packed {
      logic sample_lt_x;
      logic out_free;
   } status_type;

endpackage

/* hdl/piecewise_linear_curve_eval.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_curve_eval
// Piecewise-linear curve evaluator over a table of signed Q8.16 breakpoints.
// ----------------------------------------------------------------------------
// A load item (tuser 0) writes one breakpoint and is taken from the idle state.
// An evaluate item (tuser 1) reads the table one entry at a time, through a
// read state and a check state per breakpoint examined, then runs a
// shift-subtract divider at one bit per cycle when the sample falls inside a
// segment. The result then waits in the finish state until the result
// register is free; no new item is taken before the evaluate is finished.
// The breakpoint memory read port sets the search pace.
// Load slots not yet written read back as garbage; load every slot in use
// before evaluating and write point_count only while the block is idle.
module piecewise_linear_curve_eval #(
   parameter int MAX_POINTS  = pwl_pkg::MAX_POINTS_DEF,
   parameter int VALUE_WIDTH = pwl_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // req_tdata: point_index, point_x, point_y, sample (lowest bits first)
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((pwl_pkg::SLOT_W + 3 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // req_tuser: action
   input  logic                                    req_tuser,
   // rsp_tdata: value, segment (lowest bits first)
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((VALUE_WIDTH + pwl_pkg::SEG_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   // rsp_tuser: below_first, beyond_last
   output logic [1:0]                              rsp_tuser,
   // point_count write
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pwl_pkg::COUNT_W-1:0]             csr_data
);

   pwl_pkg::cmd_type                cmd;
   pwl_pkg::status_type             status;
   logic [$clog2(MAX_POINTS)-1:0]   rd_addr;
   logic [$clog2(MAX_POINTS)-1:0]   last_index;

   // Sequencer
   pwl_ctrl #(
      .MAX_POINTS  (MAX_POINTS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .last_index (last_index),
      .status     (status),
      .rd_addr    (rd_addr),
      .cmd        (cmd)
   );

   // Datapath
   pwl_dpath #(
      .MAX_POINTS  (MAX_POINTS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .status     (status),
      .last_index (last_index)
   );

endmodule

/* hdl/pwl_ctrl.sv */
// ----------------------------------------------------------------------------
// pwl_ctrl
// Sequencer: accepts items, walks the breakpoint table, runs the divider and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module pwl_ctrl #(
   parameter int MAX_POINTS  = pwl_pkg::MAX_POINTS_DEF,
   parameter int VALUE_WIDTH = pwl_pkg::VALUE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_tuser,
   input  logic [$clog2(MAX_POINTS)-1:0] last_index,
   input  pwl_pkg::status_type           status,
   output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
   output pwl_pkg::cmd_type              cmd
);

   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int BIT_W  = $clog2(VALUE_WIDTH);
   localparam int WIDE_W = (IDX_W + 1 > pwl_pkg::COUNT_W) ? IDX_W + 1 : pwl_pkg::COUNT_W;

   pwl_pkg::state_type         state_ff, state_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [BIT_W-1:0]           bit_ff, bit_in;
   logic [pwl_pkg::SEG_W-1:0]  seg_ff, seg_in;
   logic                       below_ff, below_in;
   logic                       beyond_ff, beyond_in;
   logic [WIDE_W-1:0]          idx_wide;

   // State and sequencing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pwl_pkg::ST_IDLE;
         idx_ff    <= '0;
         bit_ff    <= '0;
         seg_ff    <= '0;
         below_ff  <= 1'b0;
         beyond_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         bit_ff    <= bit_in;
         seg_ff    <= seg_in;
         below_ff  <= below_in;
         beyond_ff <= beyond_in;
      end
   end

   assign idx_wide = WIDE_W'(idx_ff);
   assign rd_addr  = idx_ff;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      bit_in     = bit_ff;
      seg_in     = seg_ff;
      below_in   = below_ff;
      beyond_in  = beyond_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.segment    = seg_ff;
      cmd.out_below  = below_ff;
      cmd.out_beyond = beyond_ff;
      case (state_ff)
         pwl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == pwl_pkg::ACT_EVAL) begin
                  cmd.load_sample = 1'b1;
                  idx_in          = '0;
                  state_in        = pwl_pkg::ST_READ;
               end else begin
                  cmd.table_write = 1'b1;
               end
            end
         end
         pwl_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = pwl_pkg::ST_CHECK;
         end
         pwl_pkg::ST_CHECK: begin
            if (status.sample_lt_x && idx_ff == '0) begin
               // below the first breakpoint
               cmd.capture_prev = 1'b1;
               below_in         = 1'b1;
               beyond_in        = 1'b0;
               seg_in           = '0;
               state_in         = pwl_pkg::ST_FINISH;
            end else if (status.sample_lt_x) begin
               // segment found: lower point is the previous entry
               cmd.div_start = 1'b1;
               below_in      = 1'b0;
               beyond_in     = 1'b0;
               seg_in        = pwl_pkg::SEG_W'(idx_wide - WIDE_W'(1));
               bit_in        = '0;
               state_in      = pwl_pkg::ST_DIV;
            end else if (idx_ff == last_index) begin
               // at or past the last breakpoint in use
               cmd.capture_prev = 1'b1;
               below_in         = 1'b0;
               beyond_in        = 1'b1;
               seg_in           = pwl_pkg::SEG_W'(idx_wide);
               state_in         = pwl_pkg::ST_FINISH;
            end else begin
               cmd.capture_prev = 1'b1;
               idx_in           = idx_ff + IDX_W'(1);
               state_in         = pwl_pkg::ST_READ;
            end
         end
         pwl_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            bit_in       = bit_ff + BIT_W'(1);
            if (bit_ff == BIT_W'(VALUE_WIDTH - 1)) begin
               state_in = pwl_pkg::ST_FINISH;
            end
         end
         pwl_pkg::ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = pwl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pwl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/pwl_dpath.sv */
// ----------------------------------------------------------------------------
// pwl_dpath
// Datapath: breakpoint memories, point count register, sample compare,
// serial scaled divider and the result register.
// ----------------------------------------------------------------------------
module pwl_dpath #(
   parameter int MAX_POINTS  = pwl_pkg::MAX_POINTS_DEF,
   parameter int VALUE_WIDTH = pwl_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [((pwl_pkg::SLOT_W + 3 * VALUE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pwl_pkg::COUNT_W-1:0]             csr_data,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((VALUE_WIDTH + pwl_pkg::SEG_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic [1:0]                              rsp_tuser,
   input  pwl_pkg::cmd_type                        cmd,
   input  logic [$clog2(MAX_POINTS)-1:0]           rd_addr,
   output pwl_pkg::status_type                     status,
   output logic [$clog2(MAX_POINTS)-1:0]           last_index
);

   localparam int VW     = VALUE_WIDTH;
   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int WIDE_W = (IDX_W + 1 > pwl_pkg::COUNT_W) ? IDX_W + 1 : pwl_pkg::COUNT_W;
   localparam int RSP_W  = ((VW + pwl_pkg::SEG_W + 7) / 8) * 8;
   localparam int X_LO   = pwl_pkg::SLOT_W;
   localparam int Y_LO   = pwl_pkg::SLOT_W + VW;
   localparam int S_LO   = pwl_pkg::SLOT_W + 2 * VW;

   // Input fields
   logic [pwl_pkg::SLOT_W-1:0] pt_index;
   logic signed [VW-1:0]       pt_x, pt_y, pt_sample;

   assign pt_index  = req_tdata[pwl_pkg::SLOT_W-1:0];
   assign pt_x      = req_tdata[X_LO +: VW];
   assign pt_y      = req_tdata[Y_LO +: VW];
   assign pt_sample = req_tdata[S_LO +: VW];

   // Point count register, always ready
   logic [pwl_pkg::COUNT_W-1:0] count_ff;
   logic [WIDE_W-1:0]           count_w, n_w;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= pwl_pkg::COUNT_W'(1);
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   // Breakpoints in use: zero counts as one, clamp to table depth
   always_comb begin
      count_w = WIDE_W'(count_ff);
      n_w     = (count_w == '0) ? WIDE_W'(1) : count_w;
      if (n_w > WIDE_W'(MAX_POINTS)) begin
         n_w = WIDE_W'(MAX_POINTS);
      end
   end

   assign last_index = IDX_W'(n_w - WIDE_W'(1));

   // Breakpoint memories, one write and one registered read per cycle
   logic signed [VW-1:0] break_x_mem [MAX_POINTS];
   logic signed [VW-1:0] break_y_mem [MAX_POINTS];
   logic signed [VW-1:0] x_rd_ff, y_rd_ff;
   logic                 slot_ok;
   logic [IDX_W-1:0]     wr_addr;

   assign slot_ok = WIDE_W'(pt_index) < WIDE_W'(MAX_POINTS);
   assign wr_addr = IDX_W'(pt_index);

   always_ff @(posedge clock) begin
      if (cmd.table_write && slot_ok) begin
         break_x_mem[wr_addr] <= pt_x;
         break_y_mem[wr_addr] <= pt_y;
      end
      if (cmd.rd_en) begin
         x_rd_ff <= break_x_mem[rd_addr];
         y_rd_ff <= break_y_mem[rd_addr];
      end
   end

   // Sample and lower breakpoint
   logic signed [VW-1:0] sample_ff, x_prev_ff, y_prev_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         sample_ff <= pt_sample;
      end
      if (cmd.capture_prev) begin
         x_prev_ff <= x_rd_ff;
         y_prev_ff <= y_rd_ff;
      end
   end

   assign status.sample_lt_x = sample_ff < x_rd_ff;

   // Segment set-up: offset, width and rise of the segment
   logic [VW:0] num_w, den_w, dy_w, mag_w;

   assign num_w = {sample_ff[VW-1], sample_ff} - {x_prev_ff[VW-1], x_prev_ff};
   assign den_w = {x_rd_ff[VW-1], x_rd_ff} - {x_prev_ff[VW-1], x_prev_ff};
   assign dy_w  = {y_rd_ff[VW-1], y_rd_ff} - {y_prev_ff[VW-1], y_prev_ff};
   assign mag_w = dy_w[VW] ? (~dy_w + (VW + 1)'(1)) : dy_w;

   // Serial divider: floor(num * mag / den), one bit of mag per cycle
   logic [VW-1:0]   num_ff, den_ff, mag_ff, q_ff, rem_ff;
   logic            neg_ff;
   logic [VW+1:0]   r2_w, d1_w, d2_w, rem_next_w;
   logic [1:0]      k_w;
   logic [VW:0]     q_next_w;

   assign d1_w = {2'b00, den_ff};
   assign d2_w = {1'b0, den_ff, 1'b0};
   assign r2_w = {1'b0, rem_ff, 1'b0} + (mag_ff[VW-1] ? {2'b00, num_ff} : '0);

   always_comb begin
      if (r2_w >= d2_w) begin
         k_w        = 2'd2;
         rem_next_w = r2_w - d2_w;
      end else if (r2_w >= d1_w) begin
         k_w        = 2'd1;
         rem_next_w = r2_w - d1_w;
      end else begin
         k_w        = 2'd0;
         rem_next_w = r2_w;
      end
   end

   assign q_next_w = {q_ff, 1'b0} + (VW + 1)'(k_w);

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         num_ff <= num_w[VW-1:0];
         den_ff <= den_w[VW-1:0];
         mag_ff <= mag_w[VW-1:0];
         neg_ff <= dy_w[VW];
         q_ff   <= '0;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         mag_ff <= {mag_ff[VW-2:0], 1'b0};
         q_ff   <= q_next_w[VW-1:0];
         rem_ff <= rem_next_w[VW-1:0];
      end
   end

   // Result: y0 moved towards y1 by the quotient; stays between them
   logic [VW:0]   interp_w;
   logic [VW-1:0] value_w;

   assign interp_w = neg_ff ? ({y_prev_ff[VW-1], y_prev_ff} - {1'b0, q_ff})
                            : ({y_prev_ff[VW-1], y_prev_ff} + {1'b0, q_ff});
   assign value_w  = (cmd.out_below || cmd.out_beyond) ? y_prev_ff : interp_w[VW-1:0];

   // Output register
   logic                      rsp_valid_ff;
   logic [VW-1:0]             value_ff;
   logic [pwl_pkg::SEG_W-1:0] seg_ff;
   logic                      below_ff, beyond_ff;

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         value_ff  <= value_w;
         seg_ff    <= cmd.segment;
         below_ff  <= cmd.out_below;
         beyond_ff <= cmd.out_beyond;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({seg_ff, value_ff});
   assign rsp_tuser  = {beyond_ff, below_ff};

   // Checks
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken result");

   a_offset_in_segment: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (!num_w[VW] && !den_w[VW] && num_w < den_w))
      else $error("sample outside the selected segment");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |-> rem_ff < den_ff)
      else $error("divider remainder not below divisor");

endmodule
